// ===== rtl/core/fafc_pkg.sv =====
// Shared types and constants for the fully associative FIFO cache.
// Used by fafc_cell and fully_assoc_fifo_cache; no dependencies.
package fafc_pkg;

    localparam int LINES_DEF = 16;
    localparam int ADDR_W    = 32;
    localparam int TAG_W     = 30;
    localparam int DATA_W    = 32;
    localparam int BYTE_W    = 8;
    localparam int CNT_W     = 32;
    localparam int OFF_W     = 2;

    localparam logic CMD_ACCESS     = 1'b0;
    localparam logic CMD_INVALIDATE = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [TAG_W-1:0]  tag;
        logic [DATA_W-1:0] data;
    } line_t;

    typedef struct packed {
        logic clear;
        logic compare;
        logic shift;
    } cell_ctl_t;

endpackage

// ===== rtl/core/fafc_cell.sv =====
// One cache line place: holds tag, data and valid, compares against the
// lookup tag and takes its lower neighbor's line on a shift. Uses fafc_pkg.
module fafc_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  fafc_pkg::cell_ctl_t        ctl,
    input  logic [fafc_pkg::TAG_W-1:0] lookup_tag,
    input  fafc_pkg::line_t            line_in,
    output fafc_pkg::line_t            line_out,
    output logic [fafc_pkg::DATA_W-1:0] hit_data,
    output logic                       match
);
    import fafc_pkg::*;

    logic              valid_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [DATA_W-1:0] data_reg;
    logic              match_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clear)
            begin
                valid_reg <= 1'b0;
            end
            else if (ctl.shift)
            begin
                valid_reg <= line_in.valid;
            end
            if (ctl.compare)
            begin
                match_reg <= valid_reg && (tag_reg == lookup_tag);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            tag_reg  <= line_in.tag;
            data_reg <= line_in.data;
        end
    end

    assign line_out.valid = valid_reg;
    assign line_out.tag   = tag_reg;
    assign line_out.data  = data_reg;
    assign match          = match_reg;
    assign hit_data       = match_reg ? data_reg : '0;

endmodule

// ===== rtl/core/fully_assoc_fifo_cache.sv =====
// Top level of the fully associative cache with FIFO replacement by shifting.
// Uses fafc_pkg and a chain of fafc_cell instances.
//
// Usage:
//   Input words arrive on s_tvalid/s_tready/s_tdata/s_tuser. s_tuser is the
//   command (0 byte access, 1 invalidate all lines and clear counters);
//   s_tdata carries the byte address and the fill word used on a miss.
//   Each input word gives exactly one output word on m_tvalid/m_tready with
//   the requested byte, the hit flag (m_tuser) and both running counters.
//   Flow: a word is accepted in ST_IDLE, compared in every line in ST_CMP
//   (the match flags are registered) and its result is registered in ST_UPD,
//   which waits while the output register holds an untaken result. One word
//   is in work at a time: s_tready is high only in ST_IDLE.
//   Reset clears all valid bits, both counters and the output valid flag.
//   When the receiver stalls, the finished result holds in the output
//   register; the next input word is still taken and compared, and its
//   update waits until the held result is taken.
module fully_assoc_fifo_cache #(
    parameter int LINES = fafc_pkg::LINES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // addr[31:0], fill_word[63:32]
    input  logic        s_tuser,   // cmd[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // read_byte[7:0], hits_so_far[39:8], misses_so_far[71:40]
    output logic        m_tuser    // was_hit[0]
);
    import fafc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CMP  = 3'b010,
        ST_UPD  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic              cmd_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [DATA_W-1:0] fill_reg;

    logic [CNT_W-1:0]  hits_reg, hits_next;
    logic [CNT_W-1:0]  misses_reg, misses_next;

    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_hit_reg, out_hit_next;
    logic [CNT_W-1:0]  out_hits_reg, out_misses_reg;

    line_t             chain [LINES+1];
    logic [DATA_W-1:0] cell_data [LINES];
    logic [LINES-1:0]  cell_match;
    cell_ctl_t         ctl;

    logic              accept;
    logic              commit;
    logic              any_hit;
    logic [DATA_W-1:0] sel_data;
    logic [DATA_W-1:0] src_word;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign commit   = (state_reg == ST_UPD) && (!out_valid_reg || m_tready);

    assign chain[0].valid = 1'b1;
    assign chain[0].tag   = addr_reg[ADDR_W-1:OFF_W];
    assign chain[0].data  = fill_reg;

    genvar g;
    generate
        for (g = 0; g < LINES; g++)
        begin : g_cell
            fafc_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .lookup_tag (addr_reg[ADDR_W-1:OFF_W]),
                .line_in    (chain[g]),
                .line_out   (chain[g+1]),
                .hit_data   (cell_data[g]),
                .match      (cell_match[g])
            );
        end
    endgenerate

    // at most one line can match, so an OR picks its data
    always_comb
    begin
        sel_data = '0;
        for (int i = 0; i < LINES; i++)
        begin
            sel_data = sel_data | cell_data[i];
        end
    end

    assign any_hit = |cell_match;

    always_comb
    begin
        ctl.compare = (state_reg == ST_CMP);
        ctl.clear   = commit && (cmd_reg == CMD_INVALIDATE);
        ctl.shift   = commit && (cmd_reg == CMD_ACCESS) && !any_hit;
    end

    assign src_word = any_hit ? sel_data : fill_reg;

    always_comb
    begin
        hits_next     = hits_reg;
        misses_next   = misses_reg;
        out_byte_next = '0;
        out_hit_next  = 1'b0;
        if (cmd_reg == CMD_INVALIDATE)
        begin
            hits_next   = '0;
            misses_next = '0;
        end
        else
        begin
            case (addr_reg[OFF_W-1:0])
                2'd0:    out_byte_next = src_word[7:0];
                2'd1:    out_byte_next = src_word[15:8];
                2'd2:    out_byte_next = src_word[23:16];
                default: out_byte_next = src_word[31:24];
            endcase
            out_hit_next = any_hit;
            if (any_hit)
            begin
                hits_next = hits_reg + 1'b1;
            end
            else
            begin
                misses_next = misses_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hits_reg      <= '0;
            misses_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                hits_reg      <= hits_next;
                misses_reg    <= misses_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= s_tuser;
            addr_reg <= s_tdata[31:0];
            fill_reg <= s_tdata[63:32];
        end
        if (commit)
        begin
            out_byte_reg   <= out_byte_next;
            out_hit_reg    <= out_hit_next;
            out_hits_reg   <= hits_next;
            out_misses_reg <= misses_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_misses_reg, out_hits_reg, out_byte_reg};
    assign m_tuser  = out_hit_reg;

endmodule

// ===== dv/fully_assoc_fifo_cache_chk.sv =====
`timescale 1ns / 100ps
// Checker for fully_assoc_fifo_cache: watches both stream channels, predicts each lookup result.
// It compares the results field by field and reports a failure count. Depends on fafc_pkg.
module fully_assoc_fifo_cache_chk #(
    parameter int LINES = fafc_pkg::LINES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,   // addr[31:0], fill_word[63:32]
    input  logic        s_tuser,   // cmd[0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,   // read_byte[7:0], hits_so_far[39:8], misses_so_far[71:40]
    input  logic        m_tuser,   // was_hit[0]
    output int          errors,
    output int          pending
);
    import fafc_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] rd_byte;
        logic              hit;
        logic [CNT_W-1:0]  hits;
        logic [CNT_W-1:0]  misses;
    } lookup_t;

    line_t            lines [LINES];
    logic [CNT_W-1:0] hit_cnt;
    logic [CNT_W-1:0] miss_cnt;
    lookup_t          lookup_q [$];
    int               fail_cnt = 0;

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    function automatic lookup_t predict_lookup(logic cmd, logic [ADDR_W-1:0] addr,
                                               logic [DATA_W-1:0] fill);
        lookup_t          r;
        int               found;
        logic [TAG_W-1:0] tag;
        logic [OFF_W-1:0] off;
        r     = '0;
        found = -1;
        tag   = addr[ADDR_W-1:OFF_W];
        off   = addr[OFF_W-1:0];
        if (cmd == CMD_INVALIDATE)
        begin
            for (int i = 0; i < LINES; i++)
                lines[i].valid = 1'b0;
            hit_cnt  = '0;
            miss_cnt = '0;
        end
        else
        begin
            for (int i = 0; i < LINES; i++)
                if (found < 0 && lines[i].valid && lines[i].tag == tag)
                    found = i;
            if (found >= 0)
            begin
                r.rd_byte = lines[found].data[off*BYTE_W +: BYTE_W];
                r.hit     = 1'b1;
                hit_cnt   = hit_cnt + 1'b1;
            end
            else
            begin
                for (int i = LINES - 1; i > 0; i--)
                    lines[i] = lines[i-1];
                lines[0].valid = 1'b1;
                lines[0].tag   = tag;
                lines[0].data  = fill;
                r.rd_byte = fill[off*BYTE_W +: BYTE_W];
                miss_cnt  = miss_cnt + 1'b1;
            end
        end
        r.hits   = hit_cnt;
        r.misses = miss_cnt;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            fail_cnt++;
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        lookup_t got;
        lookup_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < LINES; i++)
                lines[i] = '0;
            hit_cnt  = '0;
            miss_cnt = '0;
            lookup_q.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.rd_byte = m_tdata[7:0];
                got.hit     = m_tuser;
                got.hits    = m_tdata[39:8];
                got.misses  = m_tdata[71:40];
                if (lookup_q.size() == 0)
                begin
                    fail_cnt++;
                    $display("%0t: unexpected result word, expected none, got %h", $time, got);
                end
                else
                begin
                    want = lookup_q.pop_front();
                    check_field("read_byte", 32'(want.rd_byte), 32'(got.rd_byte));
                    check_field("was_hit", 32'(want.hit), 32'(got.hit));
                    check_field("hits_so_far", want.hits, got.hits);
                    check_field("misses_so_far", want.misses, got.misses);
                end
            end
            if (s_tvalid && s_tready)
                lookup_q.push_back(predict_lookup(s_tuser, s_tdata[31:0], s_tdata[63:32]));
        end
        pending <= lookup_q.size();
        errors  <= fail_cnt;
    end

endmodule

// ===== dv/fully_assoc_fifo_cache_test.sv =====
`timescale 1ns / 100ps
// Testbench top for fully_assoc_fifo_cache: drives access and invalidate words.
// Gives the verdict. Depends on fafc_pkg, the block and fully_assoc_fifo_cache_chk.
module fully_assoc_fifo_cache_test;
    import fafc_pkg::*;

    localparam int N_RANDOM  = 1000;
    localparam int POOL_SIZE = 24;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic        s_tuser  = CMD_ACCESS;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tuser;
    int          errors;
    int          pending;

    int          burst_left = 0;
    int          words_sent = 0;
    int          inval_sent = 0;
    int          ready_mode = 0;
    int          ready_phase = 0;
    logic [TAG_W-1:0] tag_pool [POOL_SIZE];

    always #6 clk = ~clk;

    fully_assoc_fifo_cache i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    fully_assoc_fifo_cache_chk i_chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .pending  (pending)
    );

    // receiver: m_tready follows one of four randomly chosen ready modes
    always @(posedge clk)
    begin
        ready_phase <= ready_phase + 1;
        if (ready_phase % 64 == 63)
            ready_mode <= $urandom_range(0, 3);
        case (ready_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (ready_phase % 16) < 3;
        endcase
    end

    task automatic send_word(input logic cmd, input logic [31:0] addr, input logic [31:0] fill);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {fill, addr};
        do
            @(posedge clk);
        while (!s_tready);
        burst_left--;
        words_sent++;
        if (cmd == CMD_INVALIDATE)
            inval_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);
        burst_left = 0;
    endtask

    initial
    begin
        #5ms;
        $display("Timeout");
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        int          span;
        int          pick;
        logic [31:0] addr;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: invalidate on empty, extreme addresses and fills, hits on offsets 0 to 2,
        // stale lines after invalidate, FIFO eviction of the oldest line
        send_word(CMD_INVALIDATE, 32'h0, 32'h0);
        send_word(CMD_ACCESS, 32'h0000_0000, 32'h0000_0000);
        send_word(CMD_ACCESS, 32'hFFFF_FFFF, 32'hA5C3_5A3C);
        send_word(CMD_ACCESS, 32'hFFFF_FFFC, 32'hFFFF_FFFF);
        send_word(CMD_ACCESS, 32'hFFFF_FFFD, 32'h0000_0000);
        send_word(CMD_ACCESS, 32'hFFFF_FFFE, 32'h1234_5678);
        send_word(CMD_INVALIDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_ACCESS, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
        for (int i = 1; i <= LINES_DEF; i++)
            send_word(CMD_ACCESS, (i << 2) | (i & 3), $urandom);
        send_word(CMD_ACCESS, 32'hFFFF_FFFF, 32'h8000_0001);
        drain_results();

        for (int i = 0; i < POOL_SIZE; i++)
            tag_pool[i] = TAG_W'($urandom >> 2);
        span = POOL_SIZE;
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n % 100 == 0)
                span = $urandom_range(4, POOL_SIZE);
            if (n == N_RANDOM / 2)
                drain_results();
            if ($urandom_range(0, 19) == 0)
                tag_pool[$urandom_range(0, POOL_SIZE - 1)] = TAG_W'($urandom >> 2);
            pick = $urandom_range(0, 99);
            if (pick < 2)
                send_word(CMD_INVALIDATE, $urandom, $urandom);
            else
            begin
                if (pick < 82)
                    addr = {tag_pool[$urandom_range(0, span - 1)], 2'($urandom_range(0, 3))};
                else
                    addr = $urandom;
                send_word(CMD_ACCESS, addr, $urandom);
            end
        end
        s_tvalid <= 1'b0;

        do
            @(posedge clk);
        while (pending != 0);
        repeat (10) @(posedge clk);

        $display("Sent %0d words, %0d of them invalidates, over varying tag working sets",
                 words_sent, inval_sent);
        $display("with bursty input, varied output stalls and a drain midway.");
        if (errors == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== fully_assoc_fifo_cache.f =====
rtl/core/fafc_pkg.sv
rtl/core/fafc_cell.sv
rtl/core/fully_assoc_fifo_cache.sv
dv/fully_assoc_fifo_cache_chk.sv
dv/fully_assoc_fifo_cache_test.sv
